@@ sv/cdau_pkg.sv @@
// shared types, widths, constants and calendar tables for the date advance unit
package cdau_pkg;

    localparam int ADD_WIDTH  = 10;
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 16;
    localparam int DOY_W      = 9;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // working day count must hold a full month plus the largest advance
    localparam int DAY_SUM_W  = ((ADD_WIDTH > DAY_W) ? ADD_WIDTH : DAY_W) + 1;

    localparam int IN_BITS    = DAY_W + MON_W + YEAR_W + ADD_WIDTH;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = DAY_W + MON_W + YEAR_W + DOY_W + 2;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // reciprocal for year / 100 on a 16-bit year: (y * 83887) >> 23, exact for all years
    localparam int            RECIP_W     = 17;
    localparam int            PROD_W      = YEAR_W + RECIP_W;
    localparam int            RECIP_SHIFT = 23;
    localparam int            QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
    localparam logic [YEAR_W-1:0]  CENTURY   = 16'd100;

    localparam logic [MON_W-1:0]  MON_JAN = 4'd1;
    localparam logic [MON_W-1:0]  MON_FEB = 4'd2;
    localparam logic [MON_W-1:0]  MON_MAR = 4'd3;
    localparam logic [MON_W-1:0]  MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0]  LEN_31 = 5'd31;
    localparam logic [DAY_W-1:0]  LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0]  LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0]  LEN_28 = 5'd28;
    localparam logic [DAY_W-1:0]  LEN_0  = 5'd0;

    localparam logic [DAY_W-1:0]  RST_DAY   = 5'd1;
    localparam logic [MON_W-1:0]  RST_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0] RST_YEAR  = 16'd2000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REF_DAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_YEAR  = 2'd2;

    // request kinds carried on tuser
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef struct packed {
        logic leap;
        logic done;
    } leap_status_t;

    typedef struct packed {
        logic                 over;
        logic                 wrap;
        logic [DAY_W-1:0]     len;
        logic [DAY_SUM_W-1:0] day_next;
        logic [MON_W-1:0]     month_next;
    } month_step_t;

    // month length; out-of-range months have length zero
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = LEN_30;
                4'd2:                                       len = leap ? LEN_29 : LEN_28;
                default:                                    len = LEN_0;
            endcase
            return len;
        end
    endfunction

    // days in the months before this one, february taken as 28
    function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] month);
        logic [DOY_W-1:0] cum;
        begin
            case (month)
                4'd2:    cum = 9'd31;
                4'd3:    cum = 9'd59;
                4'd4:    cum = 9'd90;
                4'd5:    cum = 9'd120;
                4'd6:    cum = 9'd151;
                4'd7:    cum = 9'd181;
                4'd8:    cum = 9'd212;
                4'd9:    cum = 9'd243;
                4'd10:   cum = 9'd273;
                4'd11:   cum = 9'd304;
                4'd12:   cum = 9'd334;
                4'd13, 4'd14, 4'd15: cum = 9'd365;
                default: cum = 9'd0;
            endcase
            return cum;
        end
    endfunction

endpackage

@@ sv/cdau_leap.sv @@
// two-stage leap year evaluator using a reciprocal multiply for the century test
module cdau_leap
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cdau_pkg::YEAR_W-1:0] year,
    output cdau_pkg::leap_status_t      status
);

    logic [cdau_pkg::PROD_W-1:0] prod;
    logic [cdau_pkg::QUOT_W-1:0] quot_reg;
    logic [cdau_pkg::YEAR_W-1:0] year_reg;
    logic                        stage1_reg;
    logic [cdau_pkg::YEAR_W-1:0] cent_rem;
    logic                        leap_next;
    logic                        leap_reg;
    logic                        done_reg;

    assign prod = cdau_pkg::PROD_W'(year) * cdau_pkg::PROD_W'(cdau_pkg::RECIP_100);

    // remainder of year / 100, zero when the year is a century
    assign cent_rem  = year_reg - cdau_pkg::YEAR_W'(quot_reg) * cdau_pkg::CENTURY;
    assign leap_next = (year_reg[1:0] == 2'b00) &&
                       ((cent_rem != '0) || (quot_reg[1:0] == 2'b00));

    always_ff @(posedge clk)
    begin
        quot_reg <= prod[cdau_pkg::PROD_W-1:cdau_pkg::RECIP_SHIFT];
        year_reg <= year;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
            leap_reg   <= 1'b1;
        end
        else
        begin
            stage1_reg <= start;
            done_reg   <= stage1_reg;
            if (stage1_reg)
            begin
                leap_reg <= leap_next;
            end
        end
    end

    assign status.leap = leap_reg;
    assign status.done = done_reg;

endmodule

@@ sv/cdau_month.sv @@
// month stepping unit: compares the day count with the month length and carries
module cdau_month
(
    input  logic [cdau_pkg::DAY_SUM_W-1:0] day,
    input  logic [cdau_pkg::MON_W-1:0]     month,
    input  logic                           leap,
    output cdau_pkg::month_step_t          step
);

    logic [cdau_pkg::DAY_W-1:0] len;

    assign len = cdau_pkg::month_len(month, leap);

    always_comb
    begin
        step.len        = len;
        step.over       = day > cdau_pkg::DAY_SUM_W'(len);
        step.day_next   = day - cdau_pkg::DAY_SUM_W'(len);
        // december and the out-of-range codes above it roll into january
        step.wrap       = month >= cdau_pkg::MON_DEC;
        step.month_next = step.wrap ? cdau_pkg::MON_JAN : (month + 1'b1);
    end

endmodule

@@ sv/calendar_date_advance_unit.sv @@
// top level of the gregorian date advance unit: sequencer, date state and result register
//
//  channel   dir  signals                      contents (low bit first)
//  s_*       in   s_tvalid/s_tready/s_tdata    load_day, load_month, load_year, days_to_add
//                 s_tuser                      action (0 load, 1 advance)
//  m_*       out  m_tvalid/m_tready/m_tdata    cur_day, cur_month, cur_year, day_of_year,
//                                              before_ref, equal_ref
//  cfg_*     in   cfg_we/cfg_index/cfg_data    0 ref_day, 1 ref_month, 2 ref_year
//
// a load passes through the leap evaluator and then the final step; an advance first adds
// the days, then passes through the leap evaluator and steps month by month to the final step
// the month stepping unit handles one month per cycle, except that each year carry reruns the
// two-stage leap evaluator before stepping goes on
// reset gives 1 january 2000 as both stored and reference date
// s_tready is high only while idle; the next request is taken while a result waits,
// and the sequencer holds its last step until the result register is free

module calendar_date_advance_unit
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cdau_pkg::IN_DATA_W-1:0]    s_tdata,   // load_day, load_month, load_year, days_to_add
    input  logic                              s_tuser,   // action

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cdau_pkg::OUT_DATA_W-1:0]   m_tdata,   // cur_day, cur_month, cur_year,
                                                         // day_of_year, before_ref, equal_ref

    input  logic                              cfg_we,
    input  logic [cdau_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdau_pkg::CFG_W-1:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEAP = 4'b0010,
        ST_STEP = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam int DW = cdau_pkg::DAY_W;
    localparam int MW = cdau_pkg::MON_W;
    localparam int YW = cdau_pkg::YEAR_W;
    localparam int AW = cdau_pkg::ADD_WIDTH;
    localparam int SW = cdau_pkg::DAY_SUM_W;

    state_t                state_reg;
    logic                  advance_reg;
    logic                  leap_go_reg;

    // date state; day is held wide while stepping, fits in five bits at rest
    logic [SW-1:0]         day_reg;
    logic [MW-1:0]         month_reg;
    logic [YW-1:0]         year_reg;

    logic [DW-1:0]         ref_day_reg;
    logic [MW-1:0]         ref_month_reg;
    logic [YW-1:0]         ref_year_reg;

    logic                          out_valid_reg;
    logic [cdau_pkg::OUT_DATA_W-1:0] out_data_reg;

    // request fields
    logic [DW-1:0]         in_day;
    logic [MW-1:0]         in_month;
    logic [YW-1:0]         in_year;
    logic [AW-1:0]         in_add;

    cdau_pkg::leap_status_t leap_status;
    cdau_pkg::month_step_t  step;

    logic                  req_take;
    logic                  out_free;
    logic [DW-1:0]         cur_day;
    logic [cdau_pkg::DOY_W-1:0] doy;
    logic                  before_ref;
    logic                  equal_ref;

    assign in_day   = s_tdata[DW-1:0];
    assign in_month = s_tdata[DW+MW-1:DW];
    assign in_year  = s_tdata[DW+MW+YW-1:DW+MW];
    assign in_add   = s_tdata[DW+MW+YW+AW-1:DW+MW+YW];

    assign s_tready = (state_reg == ST_IDLE);
    assign req_take = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    cdau_leap u_leap
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (leap_go_reg),
        .year   (year_reg),
        .status (leap_status)
    );

    cdau_month u_month
    (
        .day   (day_reg),
        .month (month_reg),
        .leap  (leap_status.leap),
        .step  (step)
    );

    // result fields from the settled date
    assign cur_day = day_reg[DW-1:0];
    assign doy     = cdau_pkg::days_before(month_reg)
                   + cdau_pkg::DOY_W'(leap_status.leap && (month_reg >= cdau_pkg::MON_MAR))
                   + cdau_pkg::DOY_W'(cur_day);

    assign equal_ref  = (year_reg == ref_year_reg) && (month_reg == ref_month_reg) &&
                        (cur_day == ref_day_reg);
    assign before_ref = (year_reg < ref_year_reg) ||
                        ((year_reg == ref_year_reg) && (month_reg < ref_month_reg)) ||
                        ((year_reg == ref_year_reg) && (month_reg == ref_month_reg) &&
                         (cur_day < ref_day_reg));

    // reference date registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_day_reg   <= cdau_pkg::RST_DAY;
            ref_month_reg <= cdau_pkg::RST_MONTH;
            ref_year_reg  <= cdau_pkg::RST_YEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cdau_pkg::REG_REF_DAY:   ref_day_reg   <= cfg_data[DW-1:0];
                cdau_pkg::REG_REF_MONTH: ref_month_reg <= cfg_data[MW-1:0];
                cdau_pkg::REG_REF_YEAR:  ref_year_reg  <= cfg_data[YW-1:0];
                default:                 ;
            endcase
        end
    end

    // sequencer and date state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            advance_reg <= 1'b0;
            leap_go_reg <= 1'b0;
            day_reg     <= SW'(cdau_pkg::RST_DAY);
            month_reg   <= cdau_pkg::RST_MONTH;
            year_reg    <= cdau_pkg::RST_YEAR;
        end
        else
        begin
            leap_go_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        advance_reg <= (s_tuser == cdau_pkg::ACT_ADVANCE);
                        leap_go_reg <= 1'b1;
                        state_reg   <= ST_LEAP;
                        if (s_tuser == cdau_pkg::ACT_ADVANCE)
                        begin
                            day_reg <= day_reg + SW'(in_add);
                        end
                        else
                        begin
                            day_reg   <= SW'(in_day);
                            month_reg <= in_month;
                            year_reg  <= in_year;
                        end
                    end
                end
                ST_LEAP:
                begin
                    if (leap_status.done)
                    begin
                        state_reg <= advance_reg ? ST_STEP : ST_DONE;
                    end
                end
                ST_STEP:
                begin
                    if (step.over)
                    begin
                        day_reg   <= step.day_next;
                        month_reg <= step.month_next;
                        if (step.wrap)
                        begin
                            // new year: february length must be re-evaluated
                            year_reg    <= year_reg + 1'b1;
                            leap_go_reg <= 1'b1;
                            state_reg   <= ST_LEAP;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= cdau_pkg::OUT_DATA_W'({equal_ref, before_ref, doy,
                                                  year_reg, month_reg, cur_day});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // leap results only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
                     leap_status.done |-> (state_reg == ST_LEAP))
        else $error("leap result outside wait state");

    // at rest the stored day always fits a calendar day field
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_IDLE) |-> (day_reg <= SW'(31)))
        else $error("stored day not normalised");

    // a taken request closes the input until its result is issued
    assert property (@(posedge clk) disable iff (!rst_n)
                     req_take |=> !s_tready)
        else $error("request taken while busy");

    // a new result only appears from the final sequencer step
    assert property (@(posedge clk) disable iff (!rst_n)
                     $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result issued outside final step");

endmodule

@@ verif/date_result_checker.sv @@
// result checker for the date advance unit: tracks the calendar state and compares every result
module date_result_checker
    import cdau_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_DATA_W-1:0]   m_tdata,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output int                      fail_count,
    output int                      pending
);

    // field positions, low bit first
    localparam int IN_MON_LSB   = DAY_W;
    localparam int IN_YEAR_LSB  = DAY_W + MON_W;
    localparam int IN_ADD_LSB   = DAY_W + MON_W + YEAR_W;
    localparam int OUT_DOY_LSB  = DAY_W + MON_W + YEAR_W;
    localparam int OUT_BEF_BIT  = OUT_DOY_LSB + DOY_W;
    localparam int OUT_EQ_BIT   = OUT_BEF_BIT + 1;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [DOY_W-1:0]  doy;
        logic              before_ref;
        logic              equal_ref;
    } date_result_t;

    date_result_t      expected_dates[$];
    int                mismatches;

    logic [DAY_W-1:0]  ref_day;
    logic [MON_W-1:0]  ref_month;
    logic [YEAR_W-1:0] ref_year;
    logic [DAY_W-1:0]  stored_day;
    logic [MON_W-1:0]  stored_month;
    logic [YEAR_W-1:0] stored_year;

    function automatic bit is_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // out-of-range months count as zero days long
    function automatic int days_in_month(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // whole-month stepping, carrying into the year with a 16-bit wrap
    task automatic roll_forward(input int add);
        int d;
        int m;
        int y;
        d = stored_day + add;
        m = stored_month;
        y = stored_year;
        while (d > days_in_month(m, y))
        begin
            d -= days_in_month(m, y);
            m++;
            if (m > MON_DEC)
            begin
                m = MON_JAN;
                y = (y + 1) % 65536;
            end
        end
        stored_day   = DAY_W'(d);
        stored_month = MON_W'(m);
        stored_year  = YEAR_W'(y);
    endtask

    function automatic date_result_t describe_date();
        date_result_t r;
        int           total;
        total = 0;
        for (int k = 1; k < stored_month && k <= MON_DEC; k++)
            total += days_in_month(k, stored_year);
        total += stored_day;
        r.day        = stored_day;
        r.month      = stored_month;
        r.year       = stored_year;
        r.doy        = DOY_W'(total);
        r.before_ref = (stored_year < ref_year) ||
                       (stored_year == ref_year && stored_month < ref_month) ||
                       (stored_year == ref_year && stored_month == ref_month &&
                        stored_day < ref_day);
        r.equal_ref  = (stored_year == ref_year) && (stored_month == ref_month) &&
                       (stored_day == ref_day);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        date_result_t want;
        if (!rst_n)
        begin
            expected_dates.delete();
            mismatches   = 0;
            ref_day      = RST_DAY;
            ref_month    = RST_MONTH;
            ref_year     = RST_YEAR;
            stored_day   = RST_DAY;
            stored_month = RST_MONTH;
            stored_year  = RST_YEAR;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REF_DAY:   ref_day   = cfg_data[DAY_W-1:0];
                    REG_REF_MONTH: ref_month = cfg_data[MON_W-1:0];
                    REG_REF_YEAR:  ref_year  = cfg_data[YEAR_W-1:0];
                    default:       ;
                endcase
            end
            // results first, so a request taken on this edge cannot cover a stray result
            if (m_tvalid && m_tready)
            begin
                if (expected_dates.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result %h with no request outstanding", $time, m_tdata);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("cur_day", want.day, m_tdata[DAY_W-1:0]);
                    check_field("cur_month", want.month, m_tdata[IN_MON_LSB +: MON_W]);
                    check_field("cur_year", want.year, m_tdata[IN_YEAR_LSB +: YEAR_W]);
                    check_field("day_of_year", want.doy, m_tdata[OUT_DOY_LSB +: DOY_W]);
                    check_field("before_ref", want.before_ref, m_tdata[OUT_BEF_BIT]);
                    check_field("equal_ref", want.equal_ref, m_tdata[OUT_EQ_BIT]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_LOAD)
                begin
                    stored_day   = s_tdata[DAY_W-1:0];
                    stored_month = s_tdata[IN_MON_LSB +: MON_W];
                    stored_year  = s_tdata[IN_YEAR_LSB +: YEAR_W];
                end
                else
                    roll_forward(int'(s_tdata[IN_ADD_LSB +: ADD_WIDTH]));
                expected_dates.push_back(describe_date());
            end
            fail_count <= mismatches;
            pending    <= expected_dates.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// top of the date advance unit testbench: clock, reset, request stimulus and verdict
module testbench;

    import cdau_pkg::*;

    // no register sits at this index; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 342;
    localparam int TAIL_CYCLES      = 64;
    // slowest run is roughly 1100 requests, some at the largest advance, plus stalls on both sides
    localparam int LIMIT_CYCLES     = 600000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int                     check_failures;
    int                     results_owed;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     cycle_count;

    // reference date as last written, so requests can aim at it
    int                     ref_d;
    int                     ref_m;
    int                     ref_y;

    calendar_date_advance_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    date_result_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (check_failures),
        .pending    (results_owed)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // hard stop in case the block hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // one request; the sender may first sit idle at random
    task automatic send_request(input logic act, input logic [DAY_W-1:0] d,
                                input logic [MON_W-1:0] m, input logic [YEAR_W-1:0] y,
                                input logic [ADD_WIDTH-1:0] add);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[IN_BITS-1:0] = {add, y, m, d};
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // unused fields get random content so every field bit of tdata toggles; the pad bits stay zero
    task automatic load_date(input int d, input int m, input int y);
        send_request(ACT_LOAD, DAY_W'(d), MON_W'(m), YEAR_W'(y), ADD_WIDTH'($urandom));
    endtask

    task automatic advance_days(input int n);
        send_request(ACT_ADVANCE, DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom),
                     ADD_WIDTH'(n));
    endtask

    // hold the sender off until every result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // upper bits of the narrow registers carry noise, the block keeps only the low bits
    task automatic set_reference(input int d, input int m, input int y);
        logic [CFG_W-1:0] word;
        word = CFG_W'($urandom);
        word[DAY_W-1:0] = DAY_W'(d);
        write_reg(REG_REF_DAY, word);
        word = CFG_W'($urandom);
        word[MON_W-1:0] = MON_W'(m);
        write_reg(REG_REF_MONTH, word);
        write_reg(REG_REF_YEAR, CFG_W'(y));
        write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_we <= 1'b0;
        ref_d = d % 32;
        ref_m = m % 16;
        ref_y = y % 65536;
    endtask

    // years that stress leap rules, the wrap and the reference comparison
    function automatic int pick_year();
        case ($urandom_range(5))
            0:       return $urandom_range(65535);
            1:       return (ref_y + $urandom_range(6) + 65533) % 65536;
            2:       return $urandom_range(65535, 65530);
            3:       return (100 * $urandom_range(655) + $urandom_range(2) + 65535) % 65536;
            4:       return $urandom_range(3);
            default: return $urandom_range(2100, 1890);
        endcase
    endfunction

    task automatic random_request();
        int pick;
        int mo;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            // valid month with a day from 1 to 31, month ends included
            mo = $urandom_range(12, 1);
            load_date(($urandom_range(9) < 7) ? $urandom_range(28, 1) : $urandom_range(31, 29),
                      mo, pick_year());
        end
        else if (pick < 26)
            load_date(ref_d, ref_m, ref_y);
        else if (pick < 30)
            // noise: any bit pattern, out-of-range day and month included
            load_date($urandom_range(31), $urandom_range(15), $urandom_range(65535));
        else if (pick < 80)
            advance_days($urandom_range(40));
        else if (pick < 95)
            advance_days($urandom_range(1023));
        else
            advance_days(($urandom_range(1)) ? 1023 : $urandom_range(366, 365));
    endtask

    // hand-picked corners: year wrap, leap rules, odd months and days, largest advance
    task automatic directed_requests();
        advance_days(0);
        load_date(15, 6, 2000);        // matches the reference
        advance_days(1);
        load_date(31, 12, 65535);
        advance_days(1);               // year wraps to zero
        load_date(28, 2, 0);
        advance_days(1);               // year zero is a leap year
        load_date(28, 2, 1900);
        advance_days(1);               // century without a leap day
        load_date(0, 0, 5);
        advance_days(0);               // day zero stays zero
        load_date(7, 0, 5);
        advance_days(0);               // month zero moves to january
        load_date(31, 15, 65535);
        advance_days(0);               // month above december carries into the year
        load_date(31, 4, 2001);
        advance_days(0);               // day past month end gets normalised
        load_date(31, 13, 2004);
        advance_days(1023);
        advance_days(1023);
        load_date(0, 14, 65535);
        advance_days(1023);
        load_date(0, 0, 0);
        advance_days(1023);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_LOAD;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_REF_DAY;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ref_d         = RST_DAY;
        ref_m         = RST_MONTH;
        ref_y         = RST_YEAR;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            // reference only changes while the block is idle
            wait_drained();
            case (phase)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 48;
                    set_reference(15, 6, 2000);
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 16;
                    set_reference(31, 15, 65535);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_reference(0, 0, 0);
                end
            endcase
            if (phase == 0)
                directed_requests();
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // mid-phase pause with the pipeline fully drained
                if (n == RANDOM_PER_PHASE / 2)
                    wait_drained();
                random_request();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (check_failures == 0 && results_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
